/* sv/plmslu_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plmslu_pkg
// Shared widths, codes, transaction types and helpers of the PLMS latent
// update block.
// ----------------------------------------------------------------------------
package plmslu_pkg;

	localparam int unsigned DATA_W            = 32;
	localparam int unsigned IDX_W             = 14;
	localparam int unsigned STEP_W            = 6;
	localparam int unsigned CFG_IDX_W         = 2;
	localparam int unsigned HIST_DEPTH        = 4;
	localparam int unsigned SLOT_W            = 2;
	localparam int unsigned ELEMENT_COUNT_DEF = 16384;

	localparam logic [CFG_IDX_W-1:0] CFG_STEP_INDEX   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SMP_GAIN     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_COEFF = 2'd2;

	localparam logic [STEP_W-1:0] STEP_WARMUP  = 6'd0;
	localparam logic [STEP_W-1:0] STEP_AVERAGE = 6'd1;
	localparam logic [STEP_W-1:0] STEP_ORDER2  = 6'd2;
	localparam logic [STEP_W-1:0] STEP_ORDER3  = 6'd3;

	localparam logic [DATA_W-1:0] SMP_GAIN_RST = 32'h0010_0000;

	typedef logic [HIST_DEPTH-1:0][DATA_W-1:0] hist_row_t;

	typedef struct packed {
		logic [IDX_W-1:0]         element_index;
		logic signed [DATA_W-1:0] sample_value;
		logic signed [DATA_W-1:0] noise_value;
	} in_item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] next_sample;
		logic                     saturated;
	} out_item_t;

	typedef struct packed {
		logic              accept;
		logic [STEP_W-1:0] step;
		logic [IDX_W-1:0]  element_index;
		logic [DATA_W-1:0] sample;
		logic [DATA_W-1:0] noise;
	} store_req_t;

	// The ring slot that receives the noise pushed at a given step.
	function automatic logic [SLOT_W-1:0] push_slot(input logic [STEP_W-1:0] step);
		logic [STEP_W-1:0] pn;
		pn = (step == STEP_WARMUP) ? STEP_WARMUP : step - 6'd1;
		return pn[SLOT_W-1:0];
	endfunction

endpackage

/* sv/plmslu_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plmslu_store
// Per-element noise history ring and warm-up sample memories with registered
// reads and lane writes issued at transaction acceptance.
// ----------------------------------------------------------------------------
module plmslu_store #(
	parameter int unsigned ELEMENT_COUNT = plmslu_pkg::ELEMENT_COUNT_DEF
) (
	input  logic                                clk,
	input  plmslu_pkg::store_req_t              req,
	output plmslu_pkg::hist_row_t               hist_row,
	output logic [plmslu_pkg::DATA_W-1:0]       warm_word
);
	import plmslu_pkg::*;

	localparam int unsigned ADDR_W = (ELEMENT_COUNT > 1) ? $clog2(ELEMENT_COUNT) : 1;
	localparam bit          WRAP   = ELEMENT_COUNT < (1 << IDX_W);
	localparam int unsigned RK     = IDX_W + ADDR_W;
	localparam int unsigned PROD_W = IDX_W + RK + 1;
	localparam logic [63:0] RECIP  =
		((64'd1 << RK) + 64'(ELEMENT_COUNT) - 64'd1) / 64'(ELEMENT_COUNT);

	hist_row_t         hist_mem [ELEMENT_COUNT];
	logic [DATA_W-1:0] warm_mem [ELEMENT_COUNT];

	logic [PROD_W-1:0] wrap_prod;
	logic [IDX_W-1:0]  wrap_quot;
	logic [IDX_W-1:0]  wrap_rem;
	logic [ADDR_W-1:0] addr;
	logic [SLOT_W-1:0] slot;

	always_comb begin
		wrap_prod = PROD_W'(req.element_index) * PROD_W'(RECIP);
		wrap_quot = wrap_prod[RK +: IDX_W];
		wrap_rem  = req.element_index - IDX_W'(wrap_quot * ELEMENT_COUNT);
		addr      = WRAP ? ADDR_W'(wrap_rem) : ADDR_W'(req.element_index);
		slot      = push_slot(req.step);
	end

	always_ff @(posedge clk) begin
		if (req.accept) begin
			if (req.step != STEP_AVERAGE) begin
				hist_mem[addr][slot] <= req.noise;
			end
			if (req.step == STEP_WARMUP) begin
				warm_mem[addr] <= req.sample;
			end
			hist_row  <= hist_mem[addr];
			warm_word <= warm_mem[addr];
		end
	end

endmodule

/* sv/plms_latent_update_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plms_latent_update_top
// Element-wise PLMS update of a diffusion latent: history ring update,
// multistep noise combination, coefficient scaling and saturation.
// ----------------------------------------------------------------------------
// Pipeline: seven register stages, the first being the memory read; the result
// is offered from the last. Throughput: one transaction per cycle while the
// output is not stalled; the history and warm-up memories are read and written
// once per element at acceptance, which sets that figure.
// Reset clears the pipeline valid bits and the configuration registers only;
// the memories are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module plms_latent_update_top #(
	parameter int unsigned ELEMENT_COUNT = plmslu_pkg::ELEMENT_COUNT_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  plmslu_pkg::in_item_t                 in_data,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output plmslu_pkg::out_item_t                out_data,
	input  logic                                 cfg_wr_en,
	input  logic [plmslu_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [plmslu_pkg::DATA_W-1:0]        cfg_data
);
	import plmslu_pkg::*;

	localparam int unsigned STAGES = 7;

	typedef enum logic [1:0] {DIV_ONE, DIV_TWO, DIV_TWELVE, DIV_TWENTYFOUR} div_code_t;

	localparam logic signed [39:0] DIV3_BIAS  = 40'sh60_0000_0000;
	localparam logic signed [39:0] DIV3_UNB   = 40'sh20_0000_0000;
	localparam logic [19:0]        RECIP_HI   = 20'd699051;
	localparam logic [22:0]        RECIP_LO   = 23'd5592406;
	localparam logic signed [47:0] WORD_MAX   = 48'sd2147483647;
	localparam logic signed [47:0] WORD_MIN   = -48'sd2147483648;
	localparam logic signed [64:0] ROUND_HALF = 65'sd524288;

	function automatic logic [DATA_W:0] clip_word(input logic signed [47:0] v);
		logic [DATA_W:0] r;
		if (v > WORD_MAX) begin
			r = {1'b1, 32'h7FFF_FFFF};
		end else if (v < WORD_MIN) begin
			r = {1'b1, 32'h8000_0000};
		end else begin
			r = {1'b0, v[DATA_W-1:0]};
		end
		return r;
	endfunction

	// Configuration.
	logic [STEP_W-1:0]        step_q;
	logic signed [DATA_W-1:0] smp_gain_q;
	logic signed [DATA_W-1:0] output_coeff_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q         <= STEP_WARMUP;
			smp_gain_q     <= SMP_GAIN_RST;
			output_coeff_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_STEP_INDEX:   step_q         <= cfg_data[STEP_W-1:0];
				CFG_SMP_GAIN:     smp_gain_q     <= cfg_data;
				CFG_OUTPUT_COEFF: output_coeff_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Pipeline flow control.
	logic [STAGES:1]   valid_q;
	logic [STAGES+1:1] adv;
	logic              accept;

	always_comb begin
		adv[STAGES+1] = !out_stall;
		for (int k = STAGES; k >= 1; k--) begin
			adv[k] = !valid_q[k] || adv[k+1];
		end
	end

	assign in_stall = !adv[1];
	assign accept   = in_valid && adv[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (adv[1]) begin
				valid_q[1] <= in_valid;
			end
			for (int k = 2; k <= STAGES; k++) begin
				if (adv[k]) begin
					valid_q[k] <= valid_q[k-1];
				end
			end
		end
	end

	// Stage 1: memory access.
	store_req_t        store_req;
	hist_row_t         row_s1;
	logic [DATA_W-1:0] warm_s1;

	always_comb begin
		store_req.accept        = accept;
		store_req.step          = step_q;
		store_req.element_index = in_data.element_index;
		store_req.sample        = in_data.sample_value;
		store_req.noise         = in_data.noise_value;
	end

	plmslu_store #(
		.ELEMENT_COUNT(ELEMENT_COUNT)
	) u_store (
		.clk      (clk),
		.req      (store_req),
		.hist_row (row_s1),
		.warm_word(warm_s1)
	);

	logic [STEP_W-1:0]        step_s1;
	logic signed [DATA_W-1:0] noise_s1;
	logic signed [DATA_W-1:0] sample_s1;

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			step_s1   <= step_q;
			noise_s1  <= in_data.noise_value;
			sample_s1 <= in_data.sample_value;
		end
	end

	// Stage 2: weighted history terms.
	logic [SLOT_W-1:0]        slot;
	logic signed [39:0]       h0x, h1x, h2x, h3x;
	logic signed [39:0]       w0_d, w1_d, w2_d, w3_d;
	div_code_t                code_d;
	logic signed [DATA_W-1:0] samp_d;

	always_comb begin
		slot = push_slot(step_s1);
		h0x  = 40'(noise_s1);
		h1x  = 40'($signed(row_s1[slot - 2'd1]));
		h2x  = 40'($signed(row_s1[slot - 2'd2]));
		h3x  = 40'($signed(row_s1[slot - 2'd3]));
		w0_d   = h0x;
		w1_d   = '0;
		w2_d   = '0;
		w3_d   = '0;
		code_d = DIV_ONE;
		samp_d = sample_s1;
		priority if (step_s1 == STEP_WARMUP) begin
			code_d = DIV_ONE;
		end else if (step_s1 == STEP_AVERAGE) begin
			w1_d   = 40'($signed(row_s1[0]));
			code_d = DIV_TWO;
			samp_d = warm_s1;
		end else if (step_s1 == STEP_ORDER2) begin
			w0_d   = 40'sd3 * h0x;
			w1_d   = -h1x;
			code_d = DIV_TWO;
		end else if (step_s1 == STEP_ORDER3) begin
			w0_d   = 40'sd23 * h0x;
			w1_d   = -(40'sd16 * h1x);
			w2_d   = 40'sd5 * h2x;
			code_d = DIV_TWELVE;
		end else begin
			w0_d   = 40'sd55 * h0x;
			w1_d   = -(40'sd59 * h1x);
			w2_d   = 40'sd37 * h2x;
			w3_d   = -(40'sd9 * h3x);
			code_d = DIV_TWENTYFOUR;
		end
	end

	logic signed [39:0]       w0_s2, w1_s2, w2_s2, w3_s2;
	div_code_t                code_s2;
	logic signed [DATA_W-1:0] samp_s2;

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			w0_s2   <= w0_d;
			w1_s2   <= w1_d;
			w2_s2   <= w2_d;
			w3_s2   <= w3_d;
			code_s2 <= code_d;
			samp_s2 <= samp_d;
		end
	end

	// Stage 3: sum, rounding offset and power-of-two part of the divisor.
	logic signed [39:0] sum_d;
	logic signed [39:0] t_d;

	always_comb begin
		sum_d = w0_s2 + w1_s2 + w2_s2 + w3_s2;
		unique case (code_s2)
			DIV_ONE:        t_d = sum_d;
			DIV_TWO:        t_d = (sum_d + 40'sd1) >>> 1;
			DIV_TWELVE:     t_d = (sum_d + 40'sd6) >>> 2;
			DIV_TWENTYFOUR: t_d = (sum_d + 40'sd12) >>> 3;
		endcase
	end

	logic signed [39:0]       t_s3;
	logic                     div3_s3;
	logic signed [DATA_W-1:0] samp_s3;

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			t_s3    <= t_d;
			div3_s3 <= (code_s2 == DIV_TWELVE) || (code_s2 == DIV_TWENTYFOUR);
			samp_s3 <= samp_s2;
		end
	end

	// Stage 4: upper digit of the floor division by three on a biased value.
	logic [39:0] biased;
	logic [18:0] u_hi;
	logic [38:0] hi_prod;
	logic [17:0] a_d;
	logic [19:0] a3_d;
	logic [19:0] hi_rem;

	always_comb begin
		biased  = 40'(t_s3 + DIV3_BIAS);
		u_hi    = biased[38:20];
		hi_prod = 39'(u_hi) * 39'(RECIP_HI);
		a_d     = hi_prod[38:21];
		a3_d    = {1'b0, a_d, 1'b0} + {2'b00, a_d};
		hi_rem  = {1'b0, u_hi} - a3_d;
	end

	logic [17:0]              a_s4;
	logic [1:0]               b_s4;
	logic [19:0]              ul_s4;
	logic signed [39:0]       t_s4;
	logic                     div3_s4;
	logic signed [DATA_W-1:0] samp_s4;

	always_ff @(posedge clk) begin
		if (adv[4]) begin
			a_s4    <= a_d;
			b_s4    <= hi_rem[1:0];
			ul_s4   <= biased[19:0];
			t_s4    <= t_s3;
			div3_s4 <= div3_s3;
			samp_s4 <= samp_s3;
		end
	end

	// Stage 5: lower digit, quotient assembly and noise saturation.
	logic [21:0]        v_lo;
	logic [44:0]        lo_prod;
	logic [19:0]        c_d;
	logic signed [39:0] quot_d;
	logic signed [39:0] comb_wide;
	logic [DATA_W:0]    comb_clip;

	always_comb begin
		v_lo      = {b_s4, ul_s4};
		lo_prod   = 45'(v_lo) * 45'(RECIP_LO);
		c_d       = lo_prod[43:24];
		quot_d    = $signed({2'b00, a_s4, c_d}) - DIV3_UNB;
		comb_wide = div3_s4 ? quot_d : t_s4;
		comb_clip = clip_word(48'(comb_wide));
	end

	logic signed [DATA_W-1:0] comb_s5;
	logic                     flag_s5;
	logic signed [DATA_W-1:0] samp_s5;

	always_ff @(posedge clk) begin
		if (adv[5]) begin
			comb_s5 <= comb_clip[DATA_W-1:0];
			flag_s5 <= comb_clip[DATA_W];
			samp_s5 <= samp_s4;
		end
	end

	// Stage 6: coefficient products.
	logic signed [63:0] p1_s6;
	logic signed [63:0] p2_s6;
	logic               flag_s6;

	always_ff @(posedge clk) begin
		if (adv[6]) begin
			p1_s6   <= smp_gain_q * samp_s5;
			p2_s6   <= output_coeff_q * comb_s5;
			flag_s6 <= flag_s5;
		end
	end

	// Stage 7: difference, rounding to Q12.20 and output saturation.
	logic signed [64:0] diff_d;
	logic [DATA_W:0]    res_clip;

	always_comb begin
		diff_d   = 65'(p1_s6) - 65'(p2_s6) + ROUND_HALF;
		res_clip = clip_word(48'($signed(diff_d[64:20])));
	end

	logic signed [DATA_W-1:0] next_s7;
	logic                     sat_s7;

	always_ff @(posedge clk) begin
		if (adv[7]) begin
			next_s7 <= res_clip[DATA_W-1:0];
			sat_s7  <= flag_s6 | res_clip[DATA_W];
		end
	end

	assign out_valid            = valid_q[STAGES];
	assign out_data.next_sample = next_s7;
	assign out_data.saturated   = sat_s7;

	// Checks.
	assert property (@(posedge clk) disable iff (!arst_n)
		!valid_q[1] |-> !in_stall)
		else $error("input stalled while the first stage is empty");

	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_q[1])
		else $error("accepted transaction did not enter the pipeline");

	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q[4] && div3_s4) |->
			((24'(c_d) * 24'd3 <= 24'(v_lo)) && (24'(v_lo) < 24'(c_d) * 24'd3 + 24'd3)))
		else $error("division by three produced a wrong quotient digit");

endmodule
